/* src/scanline_flood_fill_defines.svh */
// Assertion macros used by scanline_flood_fill.
`ifndef SCANLINE_FLOOD_FILL_DEFINES_SVH
`define SCANLINE_FLOOD_FILL_DEFINES_SVH

// Check a same-cycle implication.
`define SFF_ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Check an implication in the next cycle.
`define SFF_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

/* src/sff_pkg.sv */
package sff_pkg;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int STACK_ENTRIES = 32;
    localparam int PIXEL_BITS    = 8;
    localparam int COORD_W       = 8;
    localparam int FRAME_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int FRAME_AW      = 2 * COORD_W;
    localparam int STACK_AW      = $clog2(STACK_ENTRIES);
    localparam int LEVEL_W       = STACK_AW + 1;
    localparam int SEED_W        = 2 * COORD_W;
    localparam int SPAN_W        = COORD_W + 1;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOCHG = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    localparam logic [1:0] MODE_FG  = 2'd0;
    localparam logic [1:0] MODE_BG  = 2'd1;
    localparam logic [1:0] MODE_INV = 2'd2;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_MODE   = 3'd2;
    localparam logic [2:0] CFG_FG     = 3'd3;
    localparam logic [2:0] CFG_BG     = 3'd4;

    typedef struct packed {
        logic                  valid;
        logic [PIXEL_BITS-1:0] pixel;
        logic [1:0]            status;
    } sff_result_t;

endpackage

/* src/scanline_flood_fill.sv */
// Scanline flood fill over a 256 x 256 frame of 8-bit pixels.
// Input channel s_*: tuser carries the action (write, read, fill),
// tdata the column, row and color. Result channel m_*: one word per
// input word, tdata carrying the pixel read and a status code.
// Configuration: cfg_wr_en, cfg_addr, cfg_wr_data write the window size,
// draw mode and paint colors; the user must write them only while the block is idle (not enforced here).
// A pixel write answers in the accepting cycle, on m_* in the cycle after.
// A pixel read answers once the registered frame read has returned.
// A fill runs a sequencer over the frame memory and the seed stack, one
// frame access per cycle: a popped seed's pixel is checked, each scanned
// pixel's neighbors above and below are probed, and painted pixels written.
// The next word is taken only once the fill's result has been issued.
// Reset clears the sequencer, stack level and result valid flag; frame and
// stack contents stay undefined until written.
// While m_tready is low the result is held, and one further word is
// accepted only once the output register is free or being emptied.
module scanline_flood_fill import sff_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pos_x[7:0], pos_y[15:8], color[23:16]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // pixel_value[7:0], status[9:8], zero[15:10]
);

    `include "scanline_flood_fill_defines.svh"

    logic [FRAME_AW-1:0]   fr_addr;
    logic                  fr_we;
    logic [PIXEL_BITS-1:0] fr_wdata, fr_rdata;
    logic [STACK_AW-1:0]   st_addr;
    logic                  st_we;
    logic [SEED_W-1:0]     st_wdata, st_rdata;
    sff_result_t           res;
    logic                  m_valid_reg;
    logic [PIXEL_BITS-1:0] m_pixel_reg;
    logic [1:0]            m_status_reg;
    logic                  slot_free;

    assign slot_free = !m_valid_reg || m_tready;

    sff_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .slot_free   (slot_free),
        .in_action   (s_tuser),
        .in_x        (s_tdata[7:0]),
        .in_y        (s_tdata[15:8]),
        .in_color    (s_tdata[23:16]),
        .fr_addr     (fr_addr),
        .fr_we       (fr_we),
        .fr_wdata    (fr_wdata),
        .fr_rdata    (fr_rdata),
        .st_addr     (st_addr),
        .st_we       (st_we),
        .st_wdata    (st_wdata),
        .st_rdata    (st_rdata),
        .res         (res)
    );

    sff_ram #(.WIDTH(PIXEL_BITS), .DEPTH(FRAME_DEPTH)) u_frame (
        .aclk  (aclk),
        .addr  (fr_addr),
        .we    (fr_we),
        .wdata (fr_wdata),
        .rdata (fr_rdata)
    );

    sff_ram #(.WIDTH(SEED_W), .DEPTH(STACK_ENTRIES)) u_stack (
        .aclk  (aclk),
        .addr  (st_addr),
        .we    (st_we),
        .wdata (st_wdata),
        .rdata (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_pixel_reg  <= res.pixel;
            m_status_reg <= res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_status_reg, m_pixel_reg};

    `SFF_ASSERT_IMPLY(a_accept_slot, aclk, aresetn, s_tvalid && s_tready, slot_free)
    `SFF_ASSERT_IMPLY(a_status_legal, aclk, aresetn, m_tvalid, m_tdata[9:8] != 2'd3)
    `SFF_ASSERT_NEXT(a_write_result, aclk, aresetn,
        s_tvalid && s_tready && s_tuser == ACT_WRITE, m_tvalid)

endmodule

/* src/sff_ram.sv */
module sff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/sff_engine.sv */
module sff_engine import sff_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_addr,
    input  logic [8:0]            cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  slot_free,
    input  logic [1:0]            in_action,
    input  logic [COORD_W-1:0]    in_x,
    input  logic [COORD_W-1:0]    in_y,
    input  logic [PIXEL_BITS-1:0] in_color,
    output logic [FRAME_AW-1:0]   fr_addr,
    output logic                  fr_we,
    output logic [PIXEL_BITS-1:0] fr_wdata,
    input  logic [PIXEL_BITS-1:0] fr_rdata,
    output logic [STACK_AW-1:0]   st_addr,
    output logic                  st_we,
    output logic [SEED_W-1:0]     st_wdata,
    input  logic [SEED_W-1:0]     st_rdata,
    output sff_result_t           res
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_D, S_SEED_D, S_POP, S_POP_D, S_CTR_D, S_PRB_UP, S_PRB_UP_D,
        S_PRB_DN, S_PRB_DN_D, S_NEXT, S_SCAN_D, S_START_R, S_PAINT, S_PAINT_D
    } state_t;

    typedef enum logic [1:0] {PH_CENTER, PH_LEFT, PH_RIGHT} phase_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [SPAN_W-1:0]     cx_reg, cx_next;
    logic [COORD_W-1:0]    cy_reg, cy_next;
    logic [COORD_W-1:0]    mid_reg, mid_next;
    logic [SPAN_W-1:0]     left_reg, left_next;
    logic [SPAN_W-1:0]     xend_reg, xend_next;
    logic                  up_reg, up_next, dn_reg, dn_next;
    logic                  up0_reg, up0_next, dn0_reg, dn0_next;
    logic [PIXEL_BITS-1:0] target_reg, target_next;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic                  ovf_reg, ovf_next;

    logic [8:0]            win_w_reg, win_h_reg;
    logic [1:0]            mode_reg;
    logic [PIXEL_BITS-1:0] fg_reg, bg_reg;

    logic [SPAN_W-1:0]     wd, ht;
    logic                  already;
    logic [PIXEL_BITS-1:0] paint_val;
    logic                  can_push;

    assign wd = (win_w_reg < SPAN_W'(MAX_WIDTH)) ? win_w_reg : SPAN_W'(MAX_WIDTH);
    assign ht = (win_h_reg < SPAN_W'(MAX_HEIGHT)) ? win_h_reg : SPAN_W'(MAX_HEIGHT);
    assign can_push = level_reg < LEVEL_W'(STACK_ENTRIES);

    always_comb begin
        case (mode_reg)
            MODE_BG:  already = (fr_rdata == bg_reg);
            MODE_INV: already = 1'b0;
            default:  already = (fr_rdata == fg_reg);
        endcase
        case (mode_reg)
            MODE_BG:  paint_val = bg_reg;
            MODE_INV: paint_val = ~fr_rdata;
            default:  paint_val = fg_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_w_reg <= 9'd256;
            win_h_reg <= 9'd256;
            mode_reg  <= MODE_FG;
            fg_reg    <= 8'd255;
            bg_reg    <= 8'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WIDTH:  win_w_reg <= cfg_wr_data;
                CFG_HEIGHT: win_h_reg <= cfg_wr_data;
                CFG_MODE:   mode_reg  <= cfg_wr_data[1:0];
                CFG_FG:     fg_reg    <= cfg_wr_data[7:0];
                CFG_BG:     bg_reg    <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        mid_next    = mid_reg;
        left_next   = left_reg;
        xend_next   = xend_reg;
        up_next     = up_reg;
        dn_next     = dn_reg;
        up0_next    = up0_reg;
        dn0_next    = dn0_reg;
        target_next = target_reg;
        level_next  = level_reg;
        ovf_next    = ovf_reg;
        in_ready    = 1'b0;
        fr_addr     = {cy_reg, cx_reg[COORD_W-1:0]};
        fr_we       = 1'b0;
        fr_wdata    = paint_val;
        st_addr     = level_reg[STACK_AW-1:0];
        st_we       = 1'b0;
        st_wdata    = {cy_reg, cx_reg[COORD_W-1:0]};
        res.valid   = 1'b0;
        res.pixel   = '0;
        res.status  = ST_DONE;

        case (state_reg)
            S_IDLE: begin
                in_ready = slot_free;
                if (in_valid && slot_free) begin
                    fr_addr = {in_y, in_x};
                    case (in_action)
                        ACT_WRITE: begin
                            fr_we     = 1'b1;
                            fr_wdata  = in_color;
                            res.valid = 1'b1;
                        end
                        ACT_READ: state_next = S_RD_D;
                        ACT_FILL: begin
                            cx_next = {1'b0, in_x};
                            cy_next = in_y;
                            if ({1'b0, in_x} >= wd || {1'b0, in_y} >= ht) begin
                                res.valid  = 1'b1;
                                res.status = ST_NOCHG;
                            end else begin
                                state_next = S_SEED_D;
                            end
                        end
                        default: begin
                            res.valid  = 1'b1;
                            res.status = ST_NOCHG;
                        end
                    endcase
                end
            end
            S_RD_D: begin
                res.valid  = 1'b1;
                res.pixel  = fr_rdata;
                state_next = S_IDLE;
            end
            S_SEED_D: begin
                target_next = fr_rdata;
                if (already) begin
                    res.valid  = 1'b1;
                    res.status = ST_NOCHG;
                    state_next = S_IDLE;
                end else begin
                    st_we      = 1'b1;
                    st_addr    = '0;
                    level_next = LEVEL_W'(1);
                    ovf_next   = 1'b0;
                    state_next = S_POP;
                end
            end
            S_POP: begin
                if (level_reg == '0) begin
                    res.valid  = 1'b1;
                    res.status = ovf_reg ? ST_OVF : ST_DONE;
                    state_next = S_IDLE;
                end else begin
                    st_addr    = STACK_AW'(level_reg - LEVEL_W'(1));
                    level_next = level_reg - LEVEL_W'(1);
                    state_next = S_POP_D;
                end
            end
            S_POP_D: begin
                cx_next    = {1'b0, st_rdata[COORD_W-1:0]};
                cy_next    = st_rdata[SEED_W-1:COORD_W];
                fr_addr    = st_rdata;
                state_next = S_CTR_D;
            end
            S_CTR_D: begin
                if (fr_rdata != target_reg) begin
                    state_next = S_POP;
                end else begin
                    mid_next   = cx_reg[COORD_W-1:0];
                    up_next    = 1'b1;
                    dn_next    = 1'b1;
                    phase_next = PH_CENTER;
                    state_next = S_PRB_UP;
                end
            end
            S_PRB_UP: begin
                fr_addr = {cy_reg - COORD_W'(1), cx_reg[COORD_W-1:0]};
                state_next = (cy_reg != '0) ? S_PRB_UP_D : S_PRB_DN;
            end
            S_PRB_UP_D: begin
                st_wdata = {cy_reg - COORD_W'(1), cx_reg[COORD_W-1:0]};
                if (fr_rdata == target_reg) begin
                    if (up_reg) begin
                        up_next = 1'b0;
                        if (can_push) begin
                            st_we      = 1'b1;
                            level_next = level_reg + LEVEL_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end else begin
                    up_next = 1'b1;
                end
                state_next = S_PRB_DN;
            end
            S_PRB_DN: begin
                fr_addr = {cy_reg + COORD_W'(1), cx_reg[COORD_W-1:0]};
                state_next = (({1'b0, cy_reg} + SPAN_W'(1)) < ht) ? S_PRB_DN_D : S_NEXT;
            end
            S_PRB_DN_D: begin
                st_wdata = {cy_reg + COORD_W'(1), cx_reg[COORD_W-1:0]};
                if (fr_rdata == target_reg) begin
                    if (dn_reg) begin
                        dn_next = 1'b0;
                        if (can_push) begin
                            st_we      = 1'b1;
                            level_next = level_reg + LEVEL_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end else begin
                    dn_next = 1'b1;
                end
                state_next = S_NEXT;
            end
            S_NEXT: begin
                case (phase_reg)
                    PH_CENTER: begin
                        up0_next   = up_reg;
                        dn0_next   = dn_reg;
                        phase_next = PH_LEFT;
                        fr_addr    = {cy_reg, mid_reg - COORD_W'(1)};
                        if (mid_reg != '0) begin
                            cx_next    = {1'b0, mid_reg - COORD_W'(1)};
                            state_next = S_SCAN_D;
                        end else begin
                            left_next  = '0;
                            state_next = S_START_R;
                        end
                    end
                    PH_LEFT: begin
                        fr_addr = {cy_reg, cx_reg[COORD_W-1:0] - COORD_W'(1)};
                        if (cx_reg != '0) begin
                            cx_next    = cx_reg - SPAN_W'(1);
                            state_next = S_SCAN_D;
                        end else begin
                            left_next  = '0;
                            state_next = S_START_R;
                        end
                    end
                    default: begin
                        fr_addr = {cy_reg, cx_reg[COORD_W-1:0] + COORD_W'(1)};
                        if ((cx_reg + SPAN_W'(1)) < wd) begin
                            cx_next    = cx_reg + SPAN_W'(1);
                            state_next = S_SCAN_D;
                        end else begin
                            xend_next  = cx_reg + SPAN_W'(1);
                            cx_next    = left_reg;
                            state_next = S_PAINT;
                        end
                    end
                endcase
            end
            S_SCAN_D: begin
                if (fr_rdata != target_reg) begin
                    if (phase_reg == PH_LEFT) begin
                        left_next  = cx_reg + SPAN_W'(1);
                        state_next = S_START_R;
                    end else begin
                        xend_next  = cx_reg;
                        cx_next    = left_reg;
                        state_next = S_PAINT;
                    end
                end else begin
                    state_next = S_PRB_UP;
                end
            end
            S_START_R: begin
                up_next    = up0_reg;
                dn_next    = dn0_reg;
                phase_next = PH_RIGHT;
                fr_addr    = {cy_reg, mid_reg + COORD_W'(1)};
                if (({1'b0, mid_reg} + SPAN_W'(1)) < wd) begin
                    cx_next    = {1'b0, mid_reg} + SPAN_W'(1);
                    state_next = S_SCAN_D;
                end else begin
                    xend_next  = {1'b0, mid_reg} + SPAN_W'(1);
                    cx_next    = left_reg;
                    state_next = S_PAINT;
                end
            end
            S_PAINT: begin
                state_next = (cx_reg < xend_reg) ? S_PAINT_D : S_POP;
            end
            S_PAINT_D: begin
                fr_we      = 1'b1;
                cx_next    = cx_reg + SPAN_W'(1);
                state_next = S_PAINT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_CENTER;
            level_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            level_reg <= level_next;
            ovf_reg   <= ovf_next;
        end
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        mid_reg    <= mid_next;
        left_reg   <= left_next;
        xend_reg   <= xend_next;
        up_reg     <= up_next;
        dn_reg     <= dn_next;
        up0_reg    <= up0_next;
        dn0_reg    <= dn0_next;
        target_reg <= target_next;
    end

endmodule
